FILE: hdl/gamepad_event_to_joystick_unit_defines.svh
// assertion macros for the gamepad event to joystick unit
`ifndef GAMEPAD_EVENT_TO_JOYSTICK_UNIT_DEFINES_SVH
`define GAMEPAD_EVENT_TO_JOYSTICK_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF

`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`else

`define ASSERT_IMP(label, clk, rst_n, ante, cons)

`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: hdl/ge2j_pkg.sv
// types, codes and constants shared by the gamepad event to joystick unit
`timescale 1ns / 1ps

package ge2j_pkg;

    localparam logic [1:0] CMD_SYNC = 2'd0;
    localparam logic [1:0] CMD_KEY  = 2'd1;
    localparam logic [1:0] CMD_ABS  = 2'd2;

    localparam logic [9:0] CODE_ABS_X = 10'h000;
    localparam logic [9:0] CODE_ABS_Y = 10'h001;
    localparam logic [9:0] CODE_HAT_X = 10'h010;
    localparam logic [9:0] CODE_HAT_Y = 10'h011;

    localparam logic [9:0] KEY_A      = 10'h130;
    localparam logic [9:0] KEY_B      = 10'h131;
    localparam logic [9:0] KEY_X      = 10'h133;
    localparam logic [9:0] KEY_Y      = 10'h134;
    localparam logic [9:0] KEY_LB     = 10'h136;
    localparam logic [9:0] KEY_RB     = 10'h137;
    localparam logic [9:0] KEY_SELECT = 10'h13a;
    localparam logic [9:0] KEY_START  = 10'h13b;
    localparam logic [9:0] KEY_DUP    = 10'h220;
    localparam logic [9:0] KEY_DDOWN  = 10'h221;
    localparam logic [9:0] KEY_DLEFT  = 10'h222;
    localparam logic [9:0] KEY_DRIGHT = 10'h223;
    localparam logic [9:0] KEY_TRIG   = 10'h120;

    localparam int BTN_A      = 0;
    localparam int BTN_B      = 1;
    localparam int BTN_X      = 2;
    localparam int BTN_Y      = 3;
    localparam int BTN_LB     = 4;
    localparam int BTN_RB     = 5;
    localparam int BTN_PAUSE  = 6;
    localparam int BTN_BACK   = 7;
    localparam int BTN_DUP    = 8;
    localparam int BTN_DDOWN  = 9;
    localparam int BTN_DLEFT  = 10;
    localparam int BTN_DRIGHT = 11;
    localparam int BTN_TRIG   = 12;
    localparam int BTN_COUNT  = 13;

    localparam int             LIMIT_REGS    = 4;
    localparam logic [2:0]     REG_CONNECTED = 3'd4;

    localparam logic [1:0] DIR_CENTRE = 2'b00;
    localparam logic [1:0] DIR_POS    = 2'b01;
    localparam logic [1:0] DIR_NEG    = 2'b11;

    // floor(x / 100) as (x * DIV100_MULT) >> DIV100_SHIFT, exact for x below 2^22
    localparam logic [21:0] DIV100_MULT  = 22'd2684355;
    localparam int          DIV100_SHIFT = 28;

    localparam int DEF_LO     = -32768;
    localparam int DEF_HI     = 32767;
    localparam int DEF_HALF   = (DEF_HI - DEF_LO) / 2;
    localparam int DEF_CENTRE = DEF_LO + DEF_HALF;
    localparam int DEF_ENGAGE = DEF_HALF / 2;
    localparam int DEF_OFF    = (DEF_HALF * 35) / 100;
    localparam int DEF_H35    = DEF_HALF * 35;

    typedef struct packed {
        logic signed [17:0] centre;
        logic [14:0]        engage_thr;
        logic [14:0]        release_thr;
    } axis_thr_t;

    typedef struct packed {
        axis_thr_t [3:0] axis;
        logic [1:0]      connected;
    } cfg_view_t;

    function automatic logic [BTN_COUNT-1:0] key_bit(input logic [9:0] code);
        logic [BTN_COUNT-1:0] m;
        m = '0;
        case (code)
            KEY_A:      m[BTN_A]      = 1'b1;
            KEY_B:      m[BTN_B]      = 1'b1;
            KEY_X:      m[BTN_X]      = 1'b1;
            KEY_Y:      m[BTN_Y]      = 1'b1;
            KEY_LB:     m[BTN_LB]     = 1'b1;
            KEY_RB:     m[BTN_RB]     = 1'b1;
            KEY_START:  m[BTN_PAUSE]  = 1'b1;
            KEY_SELECT: m[BTN_BACK]   = 1'b1;
            KEY_DUP:    m[BTN_DUP]    = 1'b1;
            KEY_DDOWN:  m[BTN_DDOWN]  = 1'b1;
            KEY_DLEFT:  m[BTN_DLEFT]  = 1'b1;
            KEY_DRIGHT: m[BTN_DRIGHT] = 1'b1;
            KEY_TRIG:   m[BTN_TRIG]   = 1'b1;
            default:    m = '0;
        endcase
        return m;
    endfunction

endpackage

FILE: hdl/gamepad_event_to_joystick_unit.sv
// top level of the gamepad event to joystick unit
`timescale 1ns / 1ps

// one event item is taken every cycle while the result side is not stalled; an item sits in
// the event register, where the pad state is read and updated in a single pass, and a
// publishing sync shows its result from the result register, which is loaded from it, so the
// rate is one item per cycle while the result side is not stalled, set by the single-pass update.
// a limits write updates the axis centre and engage threshold at the write edge and the release
// threshold in the cycle after, ready for any item accepted after the write.

module gamepad_event_to_joystick_unit
    import ge2j_pkg::*;
#(
    parameter int PAD_COUNT = 2
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [5:0]         paddr,
    input  logic [63:0]        pwdata,
    output logic [63:0]        prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         command,
    input  logic               pad_index,
    input  logic [9:0]         event_code,
    input  logic signed [31:0] event_value,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               out_pad,
    output logic [7:0]         joystick_byte,
    output logic [4:0]         pad_extras
);

    cfg_view_t cfg;

    ge2j_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ge2j_core #(
        .PAD_COUNT (PAD_COUNT)
    ) u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .command       (command),
        .pad_index     (pad_index),
        .event_code    (event_code),
        .event_value   (event_value),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_pad       (out_pad),
        .joystick_byte (joystick_byte),
        .pad_extras    (pad_extras)
    );

endmodule

FILE: hdl/ge2j_cfg.sv
// configuration registers and per-axis threshold precompute
`timescale 1ns / 1ps

module ge2j_cfg
    import ge2j_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    output cfg_view_t   cfg
);

    logic [33:0]        limits_reg [LIMIT_REGS];
    logic signed [17:0] centre_reg [LIMIT_REGS];
    logic [14:0]        engage_reg [LIMIT_REGS];
    logic [14:0]        release_reg [LIMIT_REGS];
    logic [21:0]        h35_reg;
    logic               pend_reg;
    logic [1:0]         pend_idx_reg;
    logic [1:0]         mask_reg;

    logic [2:0]         idx;
    logic               wr;
    logic               lim_wr;
    logic signed [16:0] lo_raw;
    logic signed [16:0] hi_raw;
    logic signed [16:0] lo;
    logic signed [16:0] hi;
    logic [17:0]        diff;
    logic [15:0]        half;
    logic signed [17:0] centre_calc;
    logic [21:0]        h35_calc;
    logic [43:0]        off_prod;

    assign pready = 1'b1;
    assign idx    = paddr[5:3];
    assign wr     = psel && penable && pwrite;
    assign lim_wr = wr && (idx < 3'(LIMIT_REGS));

    always_comb
    begin
        lo_raw = signed'(pwdata[16:0]);
        hi_raw = signed'(pwdata[33:17]);
        if (hi_raw <= lo_raw)
        begin
            lo = 17'(DEF_LO);
            hi = 17'(DEF_HI);
        end
        else
        begin
            lo = lo_raw;
            hi = hi_raw;
        end
        diff        = {hi[16], hi} - {lo[16], lo};
        half        = diff[16:1];
        centre_calc = signed'({lo[16], lo} + {2'b00, half});
        h35_calc    = {6'b0, half} * 22'd35;
    end

    assign off_prod = {22'b0, h35_reg} * {22'b0, DIV100_MULT};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LIMIT_REGS; i++)
            begin
                limits_reg[i]  <= '0;
                centre_reg[i]  <= 18'(DEF_CENTRE);
                engage_reg[i]  <= 15'(DEF_ENGAGE);
                release_reg[i] <= 15'(DEF_OFF);
            end
            h35_reg      <= 22'(DEF_H35);
            pend_reg     <= 1'b0;
            pend_idx_reg <= '0;
            mask_reg     <= '0;
        end
        else
        begin
            pend_reg <= lim_wr;
            if (lim_wr)
            begin
                limits_reg[idx[1:0]] <= pwdata[33:0];
                centre_reg[idx[1:0]] <= centre_calc;
                engage_reg[idx[1:0]] <= half[15:1];
                h35_reg              <= h35_calc;
                pend_idx_reg         <= idx[1:0];
            end
            if (wr && idx == REG_CONNECTED)
            begin
                mask_reg <= pwdata[1:0];
            end
            // release threshold lands in the cycle after the write
            if (pend_reg)
            begin
                release_reg[pend_idx_reg] <= 15'(off_prod >> DIV100_SHIFT);
            end
        end
    end

    always_comb
    begin
        if (idx < 3'(LIMIT_REGS))
        begin
            prdata = {30'b0, limits_reg[idx[1:0]]};
        end
        else if (idx == REG_CONNECTED)
        begin
            prdata = {62'b0, mask_reg};
        end
        else
        begin
            prdata = '0;
        end
    end

    always_comb
    begin
        for (int i = 0; i < LIMIT_REGS; i++)
        begin
            cfg.axis[i].centre      = centre_reg[i];
            cfg.axis[i].engage_thr  = engage_reg[i];
            cfg.axis[i].release_thr = release_reg[i];
        end
        cfg.connected = mask_reg;
    end

endmodule

FILE: hdl/ge2j_core.sv
// event register, pad state update and result register
`timescale 1ns / 1ps
`include "gamepad_event_to_joystick_unit_defines.svh"

module ge2j_core
    import ge2j_pkg::*;
#(
    parameter int PAD_COUNT = 2
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  cfg_view_t          cfg,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         command,
    input  logic               pad_index,
    input  logic [9:0]         event_code,
    input  logic signed [31:0] event_value,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               out_pad,
    output logic [7:0]         joystick_byte,
    output logic [4:0]         pad_extras
);

    localparam int AXES = 2 * PAD_COUNT;

    logic               s1_valid_reg;
    logic [1:0]         cmd_reg;
    logic               pad_reg;
    logic [9:0]         code_reg;
    logic signed [31:0] value_reg;

    logic               out_valid_reg;
    logic               out_pad_reg;
    logic [7:0]         joy_reg;
    logic [4:0]         ext_reg;

    logic [1:0]           stick_reg [AXES];
    logic [31:0]          hat_reg [AXES];
    logic [BTN_COUNT-1:0] btn_reg [PAD_COUNT];
    logic                 pend_reg [PAD_COUNT];

    logic                 out_free;
    logic                 s1_go;
    logic                 pad_ok;
    logic                 axis_sel;
    logic [BTN_COUNT-1:0] sel_btn;
    logic                 sel_pend;
    logic [1:0]           cur_dir;
    logic [31:0]          cur_hat;
    axis_thr_t            thr;
    logic [1:0]           stick_x;
    logic [1:0]           stick_y;
    logic [31:0]          hat_x;
    logic [31:0]          hat_y;

    logic signed [33:0]   d;
    logic signed [33:0]   on_p;
    logic signed [33:0]   off_p;
    logic [1:0]           new_dir;
    logic                 is_stick;
    logic                 is_hat;
    logic                 stick_chg;
    logic                 hat_chg;
    logic [BTN_COUNT-1:0] kb;
    logic                 key_ok;
    logic [BTN_COUNT-1:0] nb;
    logic                 btn_chg;
    logic                 publish;
    logic                 any_chg;

    logic                 x_neg;
    logic                 x_pos;
    logic                 y_neg;
    logic                 y_pos;
    logic                 up;
    logic                 down;
    logic                 left;
    logic                 right;
    logic                 fire_b;
    logic [7:0]           joy_calc;
    logic [4:0]           ext_calc;

    assign out_free = !out_valid_reg || !out_stall;
    assign s1_go    = s1_valid_reg && out_free;
    assign in_stall = s1_valid_reg && !out_free;
    assign axis_sel = code_reg[0];

    // pick the addressed pad and axis
    always_comb
    begin
        pad_ok   = 1'b0;
        sel_btn  = '0;
        sel_pend = 1'b0;
        cur_dir  = DIR_CENTRE;
        cur_hat  = '0;
        thr      = cfg.axis[0];
        stick_x  = DIR_CENTRE;
        stick_y  = DIR_CENTRE;
        hat_x    = '0;
        hat_y    = '0;
        for (int p = 0; p < PAD_COUNT; p++)
        begin
            if (pad_reg == 1'(p))
            begin
                pad_ok   = cfg.connected[p];
                sel_btn  = btn_reg[p];
                sel_pend = pend_reg[p];
                stick_x  = stick_reg[2*p];
                stick_y  = stick_reg[2*p+1];
                hat_x    = hat_reg[2*p];
                hat_y    = hat_reg[2*p+1];
                for (int a = 0; a < 2; a++)
                begin
                    if (axis_sel == 1'(a))
                    begin
                        cur_dir = stick_reg[2*p+a];
                        cur_hat = hat_reg[2*p+a];
                        thr     = cfg.axis[2*p+a];
                    end
                end
            end
        end
    end

    // stick hysteresis
    always_comb
    begin
        d     = 34'(value_reg) - 34'(thr.centre);
        on_p  = signed'({19'b0, thr.engage_thr});
        off_p = signed'({19'b0, thr.release_thr});
        case (cur_dir)
            DIR_CENTRE:
            begin
                if (d >= on_p)
                    new_dir = DIR_POS;
                else if (d <= -on_p)
                    new_dir = DIR_NEG;
                else
                    new_dir = DIR_CENTRE;
            end
            DIR_POS:
            begin
                if (d < off_p)
                    new_dir = (d <= -on_p) ? DIR_NEG : DIR_CENTRE;
                else
                    new_dir = DIR_POS;
            end
            default:
            begin
                if (d > -off_p)
                    new_dir = (d >= on_p) ? DIR_POS : DIR_CENTRE;
                else
                    new_dir = DIR_NEG;
            end
        endcase
    end

    always_comb
    begin
        is_stick  = cmd_reg == CMD_ABS && (code_reg == CODE_ABS_X || code_reg == CODE_ABS_Y);
        is_hat    = cmd_reg == CMD_ABS && (code_reg == CODE_HAT_X || code_reg == CODE_HAT_Y);
        stick_chg = is_stick && new_dir != cur_dir;
        hat_chg   = is_hat && cur_hat != value_reg;
        kb        = key_bit(code_reg);
        key_ok    = cmd_reg == CMD_KEY && kb != '0 && value_reg != 32'sd2;
        nb        = (value_reg != 32'sd0) ? (sel_btn | kb) : (sel_btn & ~kb);
        btn_chg   = key_ok && nb != sel_btn;
        publish   = cmd_reg == CMD_SYNC && sel_pend;
        any_chg   = stick_chg || hat_chg || btn_chg;
    end

    // result packing, hat overrides the stick
    always_comb
    begin
        x_neg  = (hat_x != '0) ? hat_x[31] : (stick_x == DIR_NEG);
        x_pos  = (hat_x != '0) ? !hat_x[31] : (stick_x == DIR_POS);
        y_neg  = (hat_y != '0) ? hat_y[31] : (stick_y == DIR_NEG);
        y_pos  = (hat_y != '0) ? !hat_y[31] : (stick_y == DIR_POS);
        up     = y_neg || sel_btn[BTN_DUP];
        down   = y_pos || sel_btn[BTN_DDOWN];
        left   = x_neg || sel_btn[BTN_DLEFT];
        right  = x_pos || sel_btn[BTN_DRIGHT];
        if (up && down)
        begin
            up   = 1'b0;
            down = 1'b0;
        end
        if (left && right)
        begin
            left  = 1'b0;
            right = 1'b0;
        end
        fire_b   = sel_btn[BTN_A] || sel_btn[BTN_TRIG];
        joy_calc = {fire_b, 3'b000, right, left, down, up};
        ext_calc = {sel_btn[BTN_PAUSE], sel_btn[BTN_Y], sel_btn[BTN_X], sel_btn[BTN_B], fire_b};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < AXES; k++)
            begin
                stick_reg[k] <= DIR_CENTRE;
                hat_reg[k]   <= '0;
            end
            for (int p = 0; p < PAD_COUNT; p++)
            begin
                btn_reg[p]  <= '0;
                pend_reg[p] <= 1'b0;
            end
        end
        else
        begin
            if (!in_stall)
            begin
                s1_valid_reg <= in_valid;
            end
            if (out_free)
            begin
                out_valid_reg <= s1_go && pad_ok && publish;
            end
            if (s1_go && pad_ok)
            begin
                for (int p = 0; p < PAD_COUNT; p++)
                begin
                    if (pad_reg == 1'(p))
                    begin
                        for (int a = 0; a < 2; a++)
                        begin
                            if (axis_sel == 1'(a))
                            begin
                                if (stick_chg)
                                    stick_reg[2*p+a] <= new_dir;
                                if (hat_chg)
                                    hat_reg[2*p+a] <= value_reg;
                            end
                        end
                        if (btn_chg)
                            btn_reg[p] <= nb;
                        if (publish)
                            pend_reg[p] <= 1'b0;
                        else if (any_chg)
                            pend_reg[p] <= 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            cmd_reg   <= command;
            pad_reg   <= pad_index;
            code_reg  <= event_code;
            value_reg <= event_value;
        end
        if (s1_go && pad_ok && publish)
        begin
            out_pad_reg <= pad_reg;
            joy_reg     <= joy_calc;
            ext_reg     <= ext_calc;
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_pad       = out_pad_reg;
    assign joystick_byte = joy_reg;
    assign pad_extras    = ext_reg;

    `ASSERT_IMP(a_cancel_ud, clk, rst_n, out_valid_reg, !(joy_reg[0] && joy_reg[1]))
    `ASSERT_IMP(a_cancel_lr, clk, rst_n, out_valid_reg, !(joy_reg[2] && joy_reg[3]))
    `ASSERT_IMP(a_fire_a, clk, rst_n, out_valid_reg, joy_reg[7] == ext_reg[0])
    `ASSERT_IMP(a_stall_busy, clk, rst_n, in_stall, s1_valid_reg)
    `ASSERT_NEXT(a_pub_load, clk, rst_n, s1_go && pad_ok && publish, out_valid_reg)
    `ASSERT_IMP(a_rise_src, clk, rst_n, $rose(out_valid_reg), $past(s1_go))

endmodule

FILE: test/ge2j_report_checker.sv
// checker for the gamepad event to joystick unit: tracks pad state and compares reports
`timescale 1ns / 1ps

module ge2j_report_checker
    import ge2j_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic               pready,
    input  logic [5:0]         paddr,
    input  logic [63:0]        pwdata,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic [1:0]         command,
    input  logic               pad_index,
    input  logic [9:0]         event_code,
    input  logic signed [31:0] event_value,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic               out_pad,
    input  logic [7:0]         joystick_byte,
    input  logic [4:0]         pad_extras,
    output int                 mismatches,
    output int                 reports_due
);

    localparam int JOY_UP    = 0;
    localparam int JOY_DOWN  = 1;
    localparam int JOY_LEFT  = 2;
    localparam int JOY_RIGHT = 3;
    localparam int JOY_FIRE  = 7;

    typedef struct packed {
        logic       pad;
        logic [7:0] joy;
        logic [4:0] extras;
    } report_t;

    logic [33:0]          axis_limits [LIMIT_REGS];
    logic [1:0]           present;
    logic [1:0]           stick_dir [4];
    logic [31:0]          hat_value [4];
    logic [BTN_COUNT-1:0] buttons [2];
    logic [1:0]           dirty;
    report_t              report_q [$];

    function automatic logic [BTN_COUNT-1:0] button_of(input logic [9:0] code);
        logic [BTN_COUNT-1:0] one;
        one = '0;
        if (code == KEY_A)      one[BTN_A] = 1'b1;
        if (code == KEY_B)      one[BTN_B] = 1'b1;
        if (code == KEY_X)      one[BTN_X] = 1'b1;
        if (code == KEY_Y)      one[BTN_Y] = 1'b1;
        if (code == KEY_LB)     one[BTN_LB] = 1'b1;
        if (code == KEY_RB)     one[BTN_RB] = 1'b1;
        if (code == KEY_START)  one[BTN_PAUSE] = 1'b1;
        if (code == KEY_SELECT) one[BTN_BACK] = 1'b1;
        if (code == KEY_DUP)    one[BTN_DUP] = 1'b1;
        if (code == KEY_DDOWN)  one[BTN_DDOWN] = 1'b1;
        if (code == KEY_DLEFT)  one[BTN_DLEFT] = 1'b1;
        if (code == KEY_DRIGHT) one[BTN_DRIGHT] = 1'b1;
        if (code == KEY_TRIG)   one[BTN_TRIG] = 1'b1;
        return one;
    endfunction

    function automatic int dir_sign(input logic [1:0] dir);
        case (dir)
            DIR_POS: return 1;
            DIR_NEG: return -1;
            default: return 0;
        endcase
    endfunction

    function automatic int axis_sign(input int k);
        if (hat_value[k] != 32'd0)
            return hat_value[k][31] ? -1 : 1;
        return dir_sign(stick_dir[k]);
    endfunction

    task automatic move_stick(input int pad, input int axis, input longint pos);
        int     k;
        int     s;
        int     prev;
        longint lo;
        longint hi;
        longint half;
        longint centre;
        longint on_thr;
        longint off_thr;
        longint d;
        k = pad * 2 + axis;
        lo = $signed(axis_limits[k][16:0]);
        hi = $signed(axis_limits[k][33:17]);
        if (hi <= lo) begin
            lo = DEF_LO;
            hi = DEF_HI;
        end
        half = (hi - lo) / 2;
        centre = lo + half;
        on_thr = half / 2;
        off_thr = (half * 35) / 100;
        d = pos - centre;
        prev = dir_sign(stick_dir[k]);
        s = prev;
        if (s == 0) begin
            if (d >= on_thr)
                s = 1;
            else if (d <= -on_thr)
                s = -1;
        end
        else if (s > 0) begin
            if (d < off_thr)
                s = (d <= -on_thr) ? -1 : 0;
        end
        else begin
            if (d > -off_thr)
                s = (d >= on_thr) ? 1 : 0;
        end
        if (s != prev) begin
            stick_dir[k] = (s > 0) ? DIR_POS : (s < 0) ? DIR_NEG : DIR_CENTRE;
            dirty[pad] = 1'b1;
        end
    endtask

    task automatic apply_event(input logic [1:0] cmd, input logic pad, input logic [9:0] code,
                               input logic signed [31:0] value);
        int                   k;
        int                   x;
        int                   y;
        logic [BTN_COUNT-1:0] bit_mask;
        logic [BTN_COUNT-1:0] next_mask;
        logic [BTN_COUNT-1:0] b;
        report_t              rep;
        if (!present[pad])
            return;
        case (cmd)
            CMD_ABS: begin
                if (code == CODE_ABS_X)
                    move_stick(pad, 0, value);
                else if (code == CODE_ABS_Y)
                    move_stick(pad, 1, value);
                else if (code == CODE_HAT_X || code == CODE_HAT_Y) begin
                    k = pad * 2 + ((code == CODE_HAT_Y) ? 1 : 0);
                    if (hat_value[k] != value) begin
                        hat_value[k] = value;
                        dirty[pad] = 1'b1;
                    end
                end
            end
            CMD_KEY: begin
                bit_mask = button_of(code);
                if (bit_mask != '0 && value != 32'd2) begin
                    next_mask = (value != 0) ? (buttons[pad] | bit_mask)
                                             : (buttons[pad] & ~bit_mask);
                    if (next_mask != buttons[pad]) begin
                        buttons[pad] = next_mask;
                        dirty[pad] = 1'b1;
                    end
                end
            end
            CMD_SYNC: begin
                if (dirty[pad]) begin
                    b = buttons[pad];
                    x = axis_sign(pad * 2);
                    y = axis_sign(pad * 2 + 1);
                    rep = '0;
                    rep.pad = pad;
                    rep.joy[JOY_UP]    = (y < 0) || b[BTN_DUP];
                    rep.joy[JOY_DOWN]  = (y > 0) || b[BTN_DDOWN];
                    rep.joy[JOY_LEFT]  = (x < 0) || b[BTN_DLEFT];
                    rep.joy[JOY_RIGHT] = (x > 0) || b[BTN_DRIGHT];
                    // opposite directions cancel
                    if (rep.joy[JOY_UP] && rep.joy[JOY_DOWN]) begin
                        rep.joy[JOY_UP] = 1'b0;
                        rep.joy[JOY_DOWN] = 1'b0;
                    end
                    if (rep.joy[JOY_LEFT] && rep.joy[JOY_RIGHT]) begin
                        rep.joy[JOY_LEFT] = 1'b0;
                        rep.joy[JOY_RIGHT] = 1'b0;
                    end
                    rep.joy[JOY_FIRE] = b[BTN_A] || b[BTN_TRIG];
                    rep.extras = {b[BTN_PAUSE], b[BTN_Y], b[BTN_X], b[BTN_B], rep.joy[JOY_FIRE]};
                    report_q.push_back(rep);
                    dirty[pad] = 1'b0;
                end
            end
            default: ;
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        report_t got;
        report_t want;
        if (!rst_n) begin
            for (int i = 0; i < LIMIT_REGS; i++)
                axis_limits[i] = '0;
            for (int i = 0; i < 4; i++) begin
                stick_dir[i] = DIR_CENTRE;
                hat_value[i] = '0;
            end
            buttons[0] = '0;
            buttons[1] = '0;
            present = '0;
            dirty = '0;
            report_q.delete();
            reports_due = 0;
        end
        else begin
            if (psel && penable && pwrite && pready) begin
                if (paddr[5:3] < LIMIT_REGS)
                    axis_limits[paddr[4:3]] = pwdata[33:0];
                else if (paddr[5:3] == REG_CONNECTED)
                    present = pwdata[1:0];
            end
            if (out_valid && !out_stall) begin
                got = '{out_pad, joystick_byte, pad_extras};
                if (report_q.size() == 0) begin
                    $display("%0t: unexpected report expected none actual pad %0d joy %h extras %h",
                             $time, got.pad, got.joy, got.extras);
                    mismatches++;
                end
                else begin
                    want = report_q.pop_front();
                    if (got.pad !== want.pad)
                        $display("%0t: out_pad expected %0d actual %0d",
                                 $time, want.pad, got.pad);
                    if (got.joy !== want.joy)
                        $display("%0t: joystick_byte expected %h actual %h",
                                 $time, want.joy, got.joy);
                    if (got.extras !== want.extras)
                        $display("%0t: pad_extras expected %h actual %h",
                                 $time, want.extras, got.extras);
                    if (got !== want)
                        mismatches++;
                end
            end
            if (in_valid && !in_stall)
                apply_event(command, pad_index, event_code, event_value);
            reports_due = report_q.size();
        end
    end

endmodule

FILE: test/gamepad_event_to_joystick_unit_tb.sv
// testbench top for the gamepad event to joystick unit: stimulus, config writes and verdict
`timescale 1ns / 1ps

module gamepad_event_to_joystick_unit_tb
    import ge2j_pkg::*;
();

    localparam logic [1:0] CMD_OTHER   = 2'd3;
    localparam logic [2:0] REG_PAD0_X  = 3'd0;
    localparam logic [2:0] REG_PAD0_Y  = 3'd1;
    localparam logic [2:0] REG_PAD1_X  = 3'd2;
    localparam logic [2:0] REG_PAD1_Y  = 3'd3;
    localparam logic [2:0] REG_SPARE   = 3'd5;
    localparam int         QUIET_LIMIT = 5000;

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [5:0]         paddr;
    logic [63:0]        pwdata;
    logic [63:0]        prdata;
    logic               pready;
    logic               in_valid;
    logic               in_stall;
    logic [1:0]         command;
    logic               pad_index;
    logic [9:0]         event_code;
    logic signed [31:0] event_value;
    logic               out_valid;
    logic               out_stall;
    logic               out_pad;
    logic [7:0]         joystick_byte;
    logic [4:0]         pad_extras;
    int                 mismatches;
    int                 reports_due;

    int                 send_idle_pct;
    int                 recv_idle_pct;
    int                 quiet_cycles;
    longint             stim_lo [4];
    longint             stim_hi [4];
    logic [1:0]         stim_mask;

    gamepad_event_to_joystick_unit DUT (.*);

    ge2j_report_checker u_report_check (.*);

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("gamepad_event_to_joystick_unit_tb NOT OK");
        $finish;
    end

    function automatic logic [33:0] pack_range(input int lo, input int hi);
        logic [31:0] l;
        logic [31:0] h;
        l = lo;
        h = hi;
        return {h[16:0], l[16:0]};
    endfunction

    function automatic logic [9:0] pick_key();
        case ($urandom_range(BTN_COUNT - 1))
            0:       return KEY_A;
            1:       return KEY_B;
            2:       return KEY_X;
            3:       return KEY_Y;
            4:       return KEY_LB;
            5:       return KEY_RB;
            6:       return KEY_START;
            7:       return KEY_SELECT;
            8:       return KEY_DUP;
            9:       return KEY_DDOWN;
            10:      return KEY_DLEFT;
            11:      return KEY_DRIGHT;
            default: return KEY_TRIG;
        endcase
    endfunction

    task automatic reg_write(input logic [2:0] idx, input logic [63:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 3'b000};
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_limits(input logic [2:0] idx, input logic [33:0] raw);
        reg_write(idx, {30'd0, raw});
        stim_lo[idx[1:0]] = $signed(raw[16:0]);
        stim_hi[idx[1:0]] = $signed(raw[33:17]);
        if (stim_hi[idx[1:0]] <= stim_lo[idx[1:0]]) begin
            stim_lo[idx[1:0]] = DEF_LO;
            stim_hi[idx[1:0]] = DEF_HI;
        end
    endtask

    task automatic set_mask(input logic [1:0] m);
        reg_write(REG_CONNECTED, {62'd0, m});
        stim_mask = m;
    endtask

    task automatic send_event(input logic [1:0] cmd, input logic pad, input logic [9:0] code,
                              input logic [31:0] value);
        if ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct)
                @(posedge clk);
        end
        in_valid <= 1'b1;
        command <= cmd;
        pad_index <= pad;
        event_code <= code;
        event_value <= value;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // drop valid and let every report drain before touching the registers
    task automatic quiesce();
        in_valid <= 1'b0;
        @(posedge clk);
        do
            @(negedge clk);
        while (reports_due != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic random_event();
        int          pick;
        int          axis;
        int          k;
        int          span;
        int          choice;
        logic        pad;
        longint      half;
        longint      centre;
        longint      on_thr;
        longint      off_thr;
        longint      pos;
        logic [31:0] value;
        pick = $urandom_range(99);
        if (stim_mask != 2'b00 && $urandom_range(9) != 0) begin
            do
                pad = 1'($urandom_range(1));
            while (!stim_mask[pad]);
        end
        else
            pad = 1'($urandom_range(1));
        if (pick < 25)
            send_event(CMD_SYNC, pad, 10'($urandom_range(1023)), $urandom);
        else if (pick < 50) begin
            choice = $urandom_range(99);
            if (choice < 45)
                value = 32'd1;
            else if (choice < 85)
                value = 32'd0;
            else if (choice < 95)
                value = 32'd2;
            else
                value = $urandom;
            send_event(CMD_KEY, pad, ($urandom_range(99) < 85) ? pick_key()
                                                               : 10'($urandom_range(1023)),
                       value);
        end
        else if (pick < 72) begin
            axis = $urandom_range(1);
            k = pad * 2 + axis;
            half = (stim_hi[k] - stim_lo[k]) / 2;
            centre = stim_lo[k] + half;
            on_thr = half / 2;
            off_thr = (half * 35) / 100;
            choice = $urandom_range(9);
            if (choice < 7) begin
                span = int'(half * 3 / 4) + 2;
                pos = centre + longint'($urandom_range(2 * span)) - span;
            end
            else if (choice < 9) begin
                // land right on or next to the engage and release points
                case ($urandom_range(7))
                    0:       pos = centre + on_thr;
                    1:       pos = centre + on_thr - 1;
                    2:       pos = centre - on_thr;
                    3:       pos = centre - on_thr + 1;
                    4:       pos = centre + off_thr;
                    5:       pos = centre + off_thr - 1;
                    6:       pos = centre - off_thr;
                    default: pos = centre - off_thr + 1;
                endcase
            end
            else
                pos = $signed($urandom);
            value = pos[31:0];
            send_event(CMD_ABS, pad, axis ? CODE_ABS_Y : CODE_ABS_X, value);
        end
        else if (pick < 82) begin
            choice = $urandom_range(9);
            if (choice < 5)
                value = 32'd0;
            else if (choice < 7)
                value = 32'd1;
            else if (choice < 9)
                value = 32'hFFFF_FFFF;
            else
                value = $urandom;
            send_event(CMD_ABS, pad, $urandom_range(1) ? CODE_HAT_Y : CODE_HAT_X, value);
        end
        else if (pick < 92)
            send_event(CMD_ABS, pad, 10'($urandom_range(1023)), $urandom);
        else
            send_event(CMD_OTHER, pad, 10'($urandom_range(1023)), $urandom);
    endtask

    initial
    begin
        logic [63:0] raw;
        rst_n <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        in_valid <= 1'b0;
        command <= CMD_SYNC;
        pad_index <= 1'b0;
        event_code <= '0;
        event_value <= '0;
        send_idle_pct = 13;
        recv_idle_pct = 87;
        stim_mask = 2'b00;
        for (int i = 0; i < 4; i++) begin
            stim_lo[i] = DEF_LO;
            stim_hi[i] = DEF_HI;
        end
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: pad 0 present, default ranges everywhere
        set_mask(2'b01);
        send_event(CMD_KEY, 1'b1, KEY_A, 32'd1);             // absent pad
        send_event(CMD_SYNC, 1'b1, 10'd0, 32'd0);
        send_event(CMD_OTHER, 1'b0, KEY_A, 32'd1);           // ignored command
        send_event(CMD_SYNC, 1'b0, 10'd0, 32'd0);            // nothing changed
        send_event(CMD_KEY, 1'b0, KEY_A, 32'd1);
        send_event(CMD_SYNC, 1'b0, 10'h3FF, 32'hFFFF_FFFF);
        send_event(CMD_KEY, 1'b0, KEY_B, 32'd2);             // autorepeat
        send_event(CMD_KEY, 1'b0, 10'h3FF, 32'd1);           // unknown key
        send_event(CMD_ABS, 1'b0, 10'h3FF, 32'd5);           // unknown axis
        send_event(CMD_SYNC, 1'b0, 10'd0, 32'd0);
        send_event(CMD_ABS, 1'b0, CODE_ABS_X, 32'h7FFF_FFFF);
        send_event(CMD_ABS, 1'b0, CODE_ABS_Y, 32'h8000_0000);
        send_event(CMD_SYNC, 1'b0, 10'd0, 32'd0);
        send_event(CMD_ABS, 1'b0, CODE_HAT_X, 32'hFFFF_FFFF); // hat beats stick
        send_event(CMD_SYNC, 1'b0, 10'd0, 32'd0);
        send_event(CMD_KEY, 1'b0, KEY_DRIGHT, 32'd1);        // left and right cancel
        send_event(CMD_KEY, 1'b0, KEY_START, 32'h8000_0000);
        send_event(CMD_KEY, 1'b0, KEY_TRIG, 32'd1);
        send_event(CMD_KEY, 1'b0, KEY_DDOWN, 32'd1);         // up and down cancel
        send_event(CMD_SYNC, 1'b0, 10'd0, 32'd0);
        send_event(CMD_ABS, 1'b0, CODE_HAT_X, 32'd0);
        send_event(CMD_ABS, 1'b0, CODE_ABS_X, 32'd0);
        send_event(CMD_KEY, 1'b0, KEY_A, 32'd0);
        send_event(CMD_KEY, 1'b0, KEY_TRIG, 32'd0);
        send_event(CMD_SYNC, 1'b0, 10'd0, 32'd0);
        quiesce();

        // no pad present: everything is dropped
        set_mask(2'b00);
        repeat (10) random_event();
        quiesce();

        set_limits(REG_PAD0_X, pack_range(-100, 100));
        set_limits(REG_PAD0_Y, pack_range(-65536, 65535));
        set_limits(REG_PAD1_X, 34'h3_FFFF_FFFF);
        set_limits(REG_PAD1_Y, pack_range(10, 11));
        set_mask(2'b11);
        repeat (190) random_event();
        quiesce();

        send_idle_pct = 87;
        recv_idle_pct = 13;
        set_limits(REG_PAD1_X, pack_range(0, 255));
        set_limits(REG_PAD1_Y, pack_range(5, -5));
        set_mask(2'b10);
        repeat (120) random_event();
        quiesce();
        set_limits(REG_PAD0_X, pack_range(1000, 3000));
        set_limits(REG_PAD0_Y, 34'd0);
        set_mask(2'b11);
        repeat (120) random_event();
        quiesce();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        raw = {$urandom, $urandom};
        set_limits(REG_PAD0_X, raw[33:0]);
        raw = {$urandom, $urandom};
        set_limits(REG_PAD0_Y, raw[33:0]);
        raw = {$urandom, $urandom};
        set_limits(REG_PAD1_X, raw[33:0]);
        raw = {$urandom, $urandom};
        set_limits(REG_PAD1_Y, raw[33:0]);
        reg_write(REG_SPARE, {$urandom, $urandom});
        set_mask(2'b11);
        repeat (190) random_event();
        quiesce();

        if (mismatches == 0 && reports_due == 0)
            $display("gamepad_event_to_joystick_unit_tb OK");
        else
            $display("gamepad_event_to_joystick_unit_tb NOT OK");
        $finish;
    end

endmodule

FILE: gamepad_event_to_joystick_unit.f
+incdir+hdl
hdl/ge2j_pkg.sv
hdl/ge2j_cfg.sv
hdl/ge2j_core.sv
hdl/gamepad_event_to_joystick_unit.sv
test/ge2j_report_checker.sv
test/gamepad_event_to_joystick_unit_tb.sv
